@@ hdl/accel_step_and_fall_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Step and fall detector assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_STEP_AND_FALL_DETECTOR_DEFINES_SVH
`define ACCEL_STEP_AND_FALL_DETECTOR_DEFINES_SVH

// same-cycle implication
`define ASFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("asfd: same-cycle check failed");

// next-cycle implication
`define ASFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("asfd: next-cycle check failed");

`endif

@@ hdl/asfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Step and fall detector package
// Register map, reset values, shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package asfd_pkg;

   localparam int THR_W    = 20;
   localparam int MS_W     = 16;
   localparam int MAG_OUT_W = 20;
   localparam int COUNT_W  = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 20;
   localparam int Q_DEPTH  = 4;
   localparam int Q_AW     = 2;

   localparam logic [THR_W-1:0] RST_STEP_THR   = 20'd94372;
   localparam logic [MS_W-1:0]  RST_STEP_MIN   = 16'd300;
   localparam logic [THR_W-1:0] RST_FREE_FALL  = 20'd23593;
   localparam logic [THR_W-1:0] RST_IMPACT     = 20'd409600;
   localparam logic [MS_W-1:0]  RST_FALL_WIN   = 16'd500;
   localparam logic [THR_W-1:0] RST_STILL_LOW  = 20'd41943;
   localparam logic [THR_W-1:0] RST_STILL_HIGH = 20'd94372;

   typedef enum logic [CSR_AW-1:0] {
      CSR_STEP_THR   = 3'd0,
      CSR_STEP_MIN   = 3'd1,
      CSR_FREE_FALL  = 3'd2,
      CSR_IMPACT     = 3'd3,
      CSR_FALL_WIN   = 3'd4,
      CSR_STILL_LOW  = 3'd5,
      CSR_STILL_HIGH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] step_thr;
      logic [MS_W-1:0]  step_min;
      logic [THR_W-1:0] free_fall;
      logic [THR_W-1:0] impact;
      logic [MS_W-1:0]  fall_win;
      logic [THR_W-1:0] still_low;
      logic [THR_W-1:0] still_high;
   } cfg_type;

   typedef struct packed {
      logic step_hi;
      logic free_fall;
      logic impact;
      logic moving;
   } class_type;

   localparam int CLASS_W = $bits(class_type);

endpackage

`default_nettype wire

@@ hdl/asfd_front.sv @@
// ----------------------------------------------------------------------------
// Step and fall detector front end
// Squares the axes, sums them and classifies the magnitude. Two stages, no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module asfd_front #(
   parameter int SAMPLE_BITS = 10,
   parameter int TIME_BITS   = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire asfd_pkg::cfg_type         cfg,
   input  wire logic                      in_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] in_x,
   input  wire logic signed [SAMPLE_BITS-1:0] in_y,
   input  wire logic signed [SAMPLE_BITS-1:0] in_z,
   input  wire logic [TIME_BITS-1:0]      in_time,
   output logic                           out_valid,
   output logic [asfd_pkg::MAG_OUT_W-1:0] out_mag,
   output asfd_pkg::class_type            out_class,
   output logic [TIME_BITS-1:0]           out_time,
   output logic [1:0]                     inflight
);

   localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam int MAG_W = 2 * SAMPLE_BITS;
   localparam int CMP_W = (MAG_W > asfd_pkg::THR_W) ? MAG_W : asfd_pkg::THR_W;
   localparam int OUT_W = asfd_pkg::MAG_OUT_W;

   logic signed [2*SAMPLE_BITS-1:0] px, py, pz;
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [TIME_BITS-1:0] time_a_ff;
   logic valid_a_ff;

   logic [MAG_W-1:0] mag_in;
   logic [CMP_W-1:0] mag_cmp;
   asfd_pkg::class_type class_in;
   logic [CMP_W-1:0] thr_step, thr_ff, thr_imp, thr_lo, thr_hi;
   logic [OUT_W-1:0] mag_out_in;

   logic valid_b_ff;
   logic [OUT_W-1:0] mag_ff;
   asfd_pkg::class_type class_ff;
   logic [TIME_BITS-1:0] time_b_ff;

   assign px = in_x * in_x;
   assign py = in_y * in_y;
   assign pz = in_z * in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
      sqx_ff    <= px[SQ_W-1:0];
      sqy_ff    <= py[SQ_W-1:0];
      sqz_ff    <= pz[SQ_W-1:0];
      time_a_ff <= in_time;
      mag_ff    <= mag_out_in;
      class_ff  <= class_in;
      time_b_ff <= time_a_ff;
   end

   always_comb begin
      mag_in   = MAG_W'(sqx_ff) + MAG_W'(sqy_ff) + MAG_W'(sqz_ff);
      mag_cmp  = CMP_W'(mag_in);
      thr_step = CMP_W'(cfg.step_thr);
      thr_ff   = CMP_W'(cfg.free_fall);
      thr_imp  = CMP_W'(cfg.impact);
      thr_lo   = CMP_W'(cfg.still_low);
      thr_hi   = CMP_W'(cfg.still_high);
      class_in.step_hi   = mag_cmp > thr_step;
      class_in.free_fall = mag_cmp < thr_ff;
      class_in.impact    = mag_cmp > thr_imp;
      class_in.moving    = (mag_cmp < thr_lo) || (mag_cmp > thr_hi);
      mag_out_in = OUT_W'(mag_cmp);
   end

   assign out_valid = valid_b_ff;
   assign out_mag   = mag_ff;
   assign out_class = class_ff;
   assign out_time  = time_b_ff;
   assign inflight  = {1'b0, valid_a_ff} + {1'b0, valid_b_ff};

endmodule

`default_nettype wire

@@ hdl/asfd_queue.sv @@
// ----------------------------------------------------------------------------
// Step and fall detector decoupling queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module asfd_queue #(
   parameter int DATA_W = 56
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   not_empty,
   output logic [asfd_pkg::Q_AW:0] count
);

   localparam int AW = asfd_pkg::Q_AW;

   logic [DATA_W-1:0] mem [asfd_pkg::Q_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]   count_ff;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, do_pop};
      end
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   assign pop_data  = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

endmodule

`default_nettype wire

@@ hdl/asfd_back.sv @@
// ----------------------------------------------------------------------------
// Step and fall detector back end
// Step counter and fall state machine; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module asfd_back #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire asfd_pkg::cfg_type         cfg,
   input  wire logic                      q_valid,
   input  wire logic [asfd_pkg::MAG_OUT_W-1:0] q_mag,
   input  wire asfd_pkg::class_type       q_class,
   input  wire logic [TIME_BITS-1:0]      q_time,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [asfd_pkg::MAG_OUT_W-1:0] rsp_magnitude_sq,
   output logic                           rsp_step_event,
   output logic [asfd_pkg::COUNT_W-1:0]   rsp_steps_total,
   output logic                           rsp_fall_alarm,
   output logic                           rsp_fall_armed,
   output logic                           rsp_moving
);

   logic [asfd_pkg::COUNT_W-1:0] steps_ff, steps_in;
   logic [TIME_BITS-1:0] last_step_ff, last_step_in;
   logic armed_ff, armed_in;
   logic [TIME_BITS-1:0] ff_stamp_ff, ff_stamp_in;
   logic out_valid_ff;
   logic [asfd_pkg::MAG_OUT_W-1:0] mag_ff;
   logic step_ev_ff, step_ev_in;
   logic alarm_ff, alarm_in;
   logic moving_ff;
   logic [TIME_BITS-1:0] step_gap, fall_gap;

   assign q_pop = q_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      step_gap     = q_time - last_step_ff;
      fall_gap     = q_time - ff_stamp_ff;
      steps_in     = steps_ff;
      last_step_in = last_step_ff;
      armed_in     = armed_ff;
      ff_stamp_in  = ff_stamp_ff;
      step_ev_in   = 1'b0;
      alarm_in     = 1'b0;
      if (q_class.step_hi && (step_gap > TIME_BITS'(cfg.step_min))) begin
         steps_in     = steps_ff + 1'b1;
         last_step_in = q_time;
         step_ev_in   = 1'b1;
      end
      if (!armed_ff) begin
         if (q_class.free_fall) begin
            armed_in    = 1'b1;
            ff_stamp_in = q_time;
         end
      end else if (fall_gap > TIME_BITS'(cfg.fall_win)) begin
         armed_in = 1'b0;
      end else if (q_class.impact) begin
         alarm_in = 1'b1;
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff     <= '0;
         last_step_ff <= '0;
         armed_ff     <= 1'b0;
         ff_stamp_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            steps_ff     <= steps_in;
            last_step_ff <= last_step_in;
            armed_ff     <= armed_in;
            ff_stamp_ff  <= ff_stamp_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         mag_ff     <= q_mag;
         step_ev_ff <= step_ev_in;
         alarm_ff   <= alarm_in;
         moving_ff  <= q_class.moving;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_magnitude_sq = mag_ff;
   assign rsp_step_event   = step_ev_ff;
   assign rsp_steps_total  = steps_ff;
   assign rsp_fall_alarm   = alarm_ff;
   assign rsp_fall_armed   = armed_ff;
   assign rsp_moving       = moving_ff;

endmodule

`default_nettype wire

@@ hdl/accel_step_and_fall_detector.sv @@
// ----------------------------------------------------------------------------
// Accelerometer step and fall detector, top level
// Path: 2 front stages, 4-entry queue, result register, then the rsp ports.
// Throughput: 1 sample per cycle while not full; queue and front stages set full.
// Front end: squaring stage, then sum and threshold compare stage.
// Back end: step and fall state, one result register.
// Reset: synchronous; clears state, queue and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_step_and_fall_detector_defines.svh"

module accel_step_and_fall_detector #(
   parameter int SAMPLE_BITS = 10,
   parameter int TIME_BITS   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [asfd_pkg::CSR_AW-1:0]   csr_index,
   input  wire logic [asfd_pkg::CSR_DW-1:0]   csr_wdata,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  wire logic [TIME_BITS-1:0]          req_sample_time,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [asfd_pkg::MAG_OUT_W-1:0]     rsp_magnitude_sq,
   output logic                               rsp_step_event,
   output logic [asfd_pkg::COUNT_W-1:0]       rsp_steps_total,
   output logic                               rsp_fall_alarm,
   output logic                               rsp_fall_armed,
   output logic                               rsp_moving
);

   localparam int Q_DATA_W = asfd_pkg::MAG_OUT_W + asfd_pkg::CLASS_W + TIME_BITS;
   localparam int OCC_W    = asfd_pkg::Q_AW + 2;

   asfd_pkg::cfg_type cfg_ff;
   logic req_accept;

   logic front_valid;
   logic [asfd_pkg::MAG_OUT_W-1:0] front_mag;
   asfd_pkg::class_type front_class;
   logic [TIME_BITS-1:0] front_time;
   logic [1:0] inflight;

   logic [Q_DATA_W-1:0] q_wdata, q_rdata;
   logic q_pop, q_not_empty;
   logic [asfd_pkg::Q_AW:0] q_count;
   logic [OCC_W-1:0] occupancy;

   logic [asfd_pkg::MAG_OUT_W-1:0] q_mag;
   asfd_pkg::class_type q_class;
   logic [TIME_BITS-1:0] q_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_thr   <= asfd_pkg::RST_STEP_THR;
         cfg_ff.step_min   <= asfd_pkg::RST_STEP_MIN;
         cfg_ff.free_fall  <= asfd_pkg::RST_FREE_FALL;
         cfg_ff.impact     <= asfd_pkg::RST_IMPACT;
         cfg_ff.fall_win   <= asfd_pkg::RST_FALL_WIN;
         cfg_ff.still_low  <= asfd_pkg::RST_STILL_LOW;
         cfg_ff.still_high <= asfd_pkg::RST_STILL_HIGH;
      end else if (csr_wr_en) begin
         case (asfd_pkg::csr_index_type'(csr_index))
            asfd_pkg::CSR_STEP_THR:   cfg_ff.step_thr   <= csr_wdata;
            asfd_pkg::CSR_STEP_MIN:   cfg_ff.step_min   <= csr_wdata[asfd_pkg::MS_W-1:0];
            asfd_pkg::CSR_FREE_FALL:  cfg_ff.free_fall  <= csr_wdata;
            asfd_pkg::CSR_IMPACT:     cfg_ff.impact     <= csr_wdata;
            asfd_pkg::CSR_FALL_WIN:   cfg_ff.fall_win   <= csr_wdata[asfd_pkg::MS_W-1:0];
            asfd_pkg::CSR_STILL_LOW:  cfg_ff.still_low  <= csr_wdata;
            asfd_pkg::CSR_STILL_HIGH: cfg_ff.still_high <= csr_wdata;
            default: ;
         endcase
      end
   end

   // every beat in the front stages already owns a queue slot
   assign occupancy  = OCC_W'(q_count) + OCC_W'(inflight);
   assign req_full   = occupancy >= OCC_W'(asfd_pkg::Q_DEPTH);
   assign req_accept = req_push && !req_full;

   asfd_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_accept),
      .in_x     (req_accel_x),
      .in_y     (req_accel_y),
      .in_z     (req_accel_z),
      .in_time  (req_sample_time),
      .out_valid(front_valid),
      .out_mag  (front_mag),
      .out_class(front_class),
      .out_time (front_time),
      .inflight (inflight)
   );

   assign q_wdata = {front_mag, front_class, front_time};

   asfd_queue #(
      .DATA_W(Q_DATA_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_data(q_wdata),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .not_empty(q_not_empty),
      .count    (q_count)
   );

   assign {q_mag, q_class, q_time} = q_rdata;

   asfd_back #(
      .TIME_BITS(TIME_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_not_empty),
      .q_mag           (q_mag),
      .q_class         (q_class),
      .q_time          (q_time),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_magnitude_sq(rsp_magnitude_sq),
      .rsp_step_event  (rsp_step_event),
      .rsp_steps_total (rsp_steps_total),
      .rsp_fall_alarm  (rsp_fall_alarm),
      .rsp_fall_armed  (rsp_fall_armed),
      .rsp_moving      (rsp_moving)
   );

   `ASFD_ASSERT_NOW(a_no_overflow, front_valid, q_count < (asfd_pkg::Q_AW + 1)'(asfd_pkg::Q_DEPTH))
   `ASFD_ASSERT_NOW(a_occupancy, 1'b1, occupancy <= OCC_W'(asfd_pkg::Q_DEPTH))
   `ASFD_ASSERT_NOW(a_alarm_disarms, !rsp_empty && rsp_fall_alarm, !rsp_fall_armed)
   `ASFD_ASSERT_NEXT(a_pop_fills, q_pop, !rsp_empty)

endmodule

`default_nettype wire

@@ dv/tb_accel_step_and_fall_detector.sv @@
// ----------------------------------------------------------------------------
// Step and fall detector testbench
// Drives accelerometer samples through the req queue and pops results from
// the rsp queue, both with random idle bursts. Each accepted sample is run
// through an in-bench model of the step counter, the free-fall/impact
// detector and the still band, and every popped beat is compared with the
// oldest prediction. A directed table of boundary samples comes first, then
// random walking, falling and noise episodes under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_accel_step_and_fall_detector;

   localparam int SAMPLE_W     = 10;
   localparam int TIME_W       = 32;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int N_DIRECTED   = 18;

   localparam logic [asfd_pkg::CSR_AW-1:0] CSR_UNUSED = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] AX_MIN = 10'h200;
   localparam logic signed [SAMPLE_W-1:0] AX_MAX = 10'h1FF;
   localparam logic signed [SAMPLE_W-1:0] AX_ZERO = 10'h000;

   typedef struct packed {
      logic [asfd_pkg::MAG_OUT_W-1:0] magnitude_sq;
      logic                           step_event;
      logic [asfd_pkg::COUNT_W-1:0]   steps_total;
      logic                           fall_alarm;
      logic                           fall_armed;
      logic                           moving;
   } motion_result_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
      logic [TIME_W-1:0]          t;
      logic                       known;
      motion_result_type          res;
   } sample_row_type;

   typedef enum int {SK_FREE, SK_REST, SK_PEAK, SK_IMPACT, SK_ANY} sample_kind_type;

   // rows marked known carry the result read straight off the detector rules
   localparam sample_row_type DIRECTED [N_DIRECTED] = '{
      '{AX_ZERO, AX_ZERO, AX_ZERO, 32'd0, 1'b1,
        '{20'd0, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1}},
      '{AX_MIN, AX_MIN, AX_MIN, 32'd100, 1'b1,
        '{20'd786432, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1}},
      '{AX_MAX, AX_MAX, AX_MAX, 32'd301, 1'b1,
        '{20'd783363, 1'b1, 32'd1, 1'b0, 1'b0, 1'b1}},
      '{AX_MAX, AX_ZERO, AX_ZERO, 32'd601, 1'b1,
        '{20'd261121, 1'b0, 32'd1, 1'b0, 1'b0, 1'b1}},
      '{AX_ZERO, AX_ZERO, AX_MIN, 32'd602, 1'b1,
        '{20'd262144, 1'b1, 32'd2, 1'b0, 1'b0, 1'b1}},
      '{10'sd256, AX_ZERO, AX_ZERO, 32'd700, 1'b1,
        '{20'd65536, 1'b0, 32'd2, 1'b0, 1'b0, 1'b0}},
      '{10'sd10, 10'sd10, 10'sd10, 32'd1000, 1'b1,
        '{20'd300, 1'b0, 32'd2, 1'b0, 1'b1, 1'b1}},
      '{AX_MIN, AX_MIN, AX_ZERO, 32'd1501, 1'b1,
        '{20'd524288, 1'b1, 32'd3, 1'b0, 1'b0, 1'b1}},
      '{AX_ZERO, AX_ZERO, AX_ZERO, 32'd1600, 1'b1,
        '{20'd0, 1'b0, 32'd3, 1'b0, 1'b1, 1'b1}},
      '{AX_ZERO, AX_ZERO, AX_ZERO, 32'd2101, 1'b1,
        '{20'd0, 1'b0, 32'd3, 1'b0, 1'b0, 1'b1}},
      '{AX_ZERO, AX_ZERO, AX_ZERO, 32'd2102, 1'b1,
        '{20'd0, 1'b0, 32'd3, 1'b0, 1'b1, 1'b1}},
      '{AX_ZERO, AX_MIN, AX_MIN, 32'd2602, 1'b1,
        '{20'd524288, 1'b1, 32'd4, 1'b1, 1'b0, 1'b1}},
      '{AX_ZERO, AX_ZERO, AX_ZERO, 32'hFFFF_FF00, 1'b1,
        '{20'd0, 1'b0, 32'd4, 1'b0, 1'b1, 1'b1}},
      '{AX_MIN, AX_MIN, AX_ZERO, 32'h0000_0010, 1'b1,
        '{20'd524288, 1'b1, 32'd5, 1'b1, 1'b0, 1'b1}},
      '{10'sd1, 10'h3FF, 10'h3FE, 32'h0000_0020, 1'b0, '0},
      '{10'h300, 10'sd255, 10'sd128, 32'h7FFF_FFFF, 1'b0, '0},
      '{10'sd170, 10'h2AB, 10'sd85, 32'h8000_0000, 1'b0, '0},
      '{10'h3FF, AX_ZERO, AX_MAX, 32'hFFFF_FFFF, 1'b0, '0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [asfd_pkg::CSR_AW-1:0]    csr_index = '0;
   logic [asfd_pkg::CSR_DW-1:0]    csr_wdata = '0;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic signed [SAMPLE_W-1:0]     req_accel_x = '0;
   logic signed [SAMPLE_W-1:0]     req_accel_y = '0;
   logic signed [SAMPLE_W-1:0]     req_accel_z = '0;
   logic [TIME_W-1:0]              req_sample_time = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [asfd_pkg::MAG_OUT_W-1:0] rsp_magnitude_sq;
   logic                           rsp_step_event;
   logic [asfd_pkg::COUNT_W-1:0]   rsp_steps_total;
   logic                           rsp_fall_alarm;
   logic                           rsp_fall_armed;
   logic                           rsp_moving;

   // detector model state
   asfd_pkg::cfg_type model_cfg;
   logic [31:0]       steps_seen = '0;
   logic [TIME_W-1:0] last_step_ms = '0;
   logic              armed_now = 1'b0;
   logic [TIME_W-1:0] fall_start_ms = '0;

   motion_result_type expected_motion [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                stall_left = 0;
   bit                sender_gaps = 1'b1;
   bit                receiver_gaps = 1'b1;
   logic [TIME_W-1:0] clock_ms = '0;

   accel_step_and_fall_detector #(
      .SAMPLE_BITS(SAMPLE_W),
      .TIME_BITS  (TIME_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_sample_time (req_sample_time),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_magnitude_sq(rsp_magnitude_sq),
      .rsp_step_event  (rsp_step_event),
      .rsp_steps_total (rsp_steps_total),
      .rsp_fall_alarm  (rsp_fall_alarm),
      .rsp_fall_armed  (rsp_fall_armed),
      .rsp_moving      (rsp_moving)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic motion_result_type predict_motion(
      input logic signed [SAMPLE_W-1:0] ax, ay, az,
      input logic [TIME_W-1:0] now);
      motion_result_type r;
      int mag;
      r = '0;
      mag = int'(ax) * int'(ax) + int'(ay) * int'(ay) + int'(az) * int'(az);
      if (mag > model_cfg.step_thr && now - last_step_ms > model_cfg.step_min) begin
         steps_seen = steps_seen + 1;
         last_step_ms = now;
         r.step_event = 1'b1;
      end
      if (!armed_now) begin
         if (mag < model_cfg.free_fall) begin
            armed_now = 1'b1;
            fall_start_ms = now;
         end
      end else if (now - fall_start_ms > model_cfg.fall_win) begin
         armed_now = 1'b0;
      end else if (mag > model_cfg.impact) begin
         r.fall_alarm = 1'b1;
         armed_now = 1'b0;
      end
      r.magnitude_sq = mag[asfd_pkg::MAG_OUT_W-1:0];
      r.steps_total = steps_seen;
      r.fall_armed = armed_now;
      r.moving = (mag < model_cfg.still_low) || (mag > model_cfg.still_high);
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_axis(input int lo, input int hi);
      int v;
      v = $urandom_range(hi, lo);
      if (v == 512 || $urandom_range(0, 1) == 1) begin
         v = -v;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic write_reg(input logic [asfd_pkg::CSR_AW-1:0] idx,
                            input logic [asfd_pkg::CSR_DW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         asfd_pkg::CSR_STEP_THR:   model_cfg.step_thr = data;
         asfd_pkg::CSR_STEP_MIN:   model_cfg.step_min = data[asfd_pkg::MS_W-1:0];
         asfd_pkg::CSR_FREE_FALL:  model_cfg.free_fall = data;
         asfd_pkg::CSR_IMPACT:     model_cfg.impact = data;
         asfd_pkg::CSR_FALL_WIN:   model_cfg.fall_win = data[asfd_pkg::MS_W-1:0];
         asfd_pkg::CSR_STILL_LOW:  model_cfg.still_low = data;
         asfd_pkg::CSR_STILL_HIGH: model_cfg.still_high = data;
         default: ;
      endcase
   endtask

   // upper bits of the 16-bit registers get junk, which must be dropped
   task automatic apply_config(input asfd_pkg::cfg_type c);
      write_reg(asfd_pkg::CSR_STEP_THR, c.step_thr);
      write_reg(asfd_pkg::CSR_STEP_MIN, {4'($urandom_range(0, 15)), c.step_min});
      write_reg(asfd_pkg::CSR_FREE_FALL, c.free_fall);
      write_reg(asfd_pkg::CSR_IMPACT, c.impact);
      write_reg(asfd_pkg::CSR_FALL_WIN, {4'($urandom_range(0, 15)), c.fall_win});
      write_reg(asfd_pkg::CSR_STILL_LOW, c.still_low);
      write_reg(asfd_pkg::CSR_STILL_HIGH, c.still_high);
      write_reg(CSR_UNUSED, asfd_pkg::CSR_DW'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] ax, ay, az,
                              input logic [TIME_W-1:0] now, input logic known,
                              input motion_result_type known_res);
      motion_result_type predicted;
      req_push <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_sample_time <= now;
      do @(posedge clock); while (req_full);
      predicted = predict_motion(ax, ay, az, now);
      expected_motion.push_back(known ? known_res : predicted);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_kind(input sample_kind_type kind, input logic [TIME_W-1:0] dt);
      logic signed [SAMPLE_W-1:0] ax, ay, az;
      case (kind)
         SK_FREE: begin
            ax = rand_axis(0, 80); ay = rand_axis(0, 80); az = rand_axis(0, 80);
         end
         SK_REST: begin
            ax = rand_axis(0, 40); ay = rand_axis(0, 40); az = rand_axis(230, 280);
         end
         SK_PEAK: begin
            ax = rand_axis(250, 340); ay = rand_axis(250, 340); az = rand_axis(250, 340);
         end
         SK_IMPACT: begin
            ax = rand_axis(380, 512); ay = rand_axis(380, 512); az = rand_axis(380, 512);
         end
         default: begin
            ax = rand_axis(0, 512); ay = rand_axis(0, 512); az = rand_axis(0, 512);
         end
      endcase
      clock_ms = clock_ms + dt;
      push_sample(ax, ay, az, clock_ms, 1'b0, '0);
   endtask

   // episodes: walking (peak/rest at step pace), falls (free fall then
   // impact near the window edge), and noise with arbitrary time jumps
   task automatic send_random(input int count);
      int sent, k, len, episode, elapsed;
      logic [TIME_W-1:0] dt;
      sample_kind_type kind;
      sent = 0;
      while (sent < count) begin
         episode = $urandom_range(0, 9);
         len = $urandom_range(2, 8);
         elapsed = 0;
         for (k = 0; k < len; k++) begin
            if (episode < 4) begin
               kind = (k % 2 == 0) ? SK_PEAK : SK_REST;
               dt = $urandom_range(0, int'(model_cfg.step_min) + 80);
            end else if (episode < 8) begin
               if (k == 0) begin
                  kind = SK_FREE;
                  dt = $urandom_range(0, 200);
               end else if (k < len - 1) begin
                  kind = ($urandom_range(0, 1) == 1) ? SK_FREE : SK_ANY;
                  dt = $urandom_range(0, 60);
                  elapsed = elapsed + int'(dt);
               end else begin
                  kind = SK_IMPACT;
                  case ($urandom_range(0, 3))
                     0: dt = int'(model_cfg.fall_win) - elapsed;
                     1: dt = int'(model_cfg.fall_win) - elapsed + 1;
                     default: dt = $urandom_range(0, int'(model_cfg.fall_win) + 100);
                  endcase
               end
            end else begin
               kind = sample_kind_type'($urandom_range(0, 4));
               case ($urandom_range(0, 4))
                  0: dt = $urandom;
                  1: dt = '0;
                  2: dt = TIME_W'(model_cfg.step_min);
                  3: dt = TIME_W'(model_cfg.step_min) + 32'd1;
                  default: dt = $urandom_range(0, 1000);
               endcase
            end
            send_kind(kind, dt);
            sent++;
         end
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input motion_result_type want,
                                  input motion_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: exp mag=%0d step=%0b total=%0d alarm=%0b armed=%0b mov=%0b",
                  $realtime, what, want.magnitude_sq, want.step_event, want.steps_total,
                  want.fall_alarm, want.fall_armed, want.moving);
         $display("%0t: %s: got mag=%0d step=%0b total=%0d alarm=%0b armed=%0b mov=%0b",
                  $realtime, what, got.magnitude_sq, got.step_event, got.steps_total,
                  got.fall_alarm, got.fall_armed, got.moving);
      end
   endtask

   always @(posedge clock) begin
      motion_result_type got;
      motion_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_accel_step_and_fall_detector failed");
         $finish;
      end else begin
         if (!reset && rsp_pop && !rsp_empty) begin
            got = {rsp_magnitude_sq, rsp_step_event, rsp_steps_total,
                   rsp_fall_alarm, rsp_fall_armed, rsp_moving};
            if (expected_motion.size() == 0) begin
               report_mismatch("unexpected beat", '0, got);
            end else begin
               want = expected_motion.pop_front();
               if (got !== want) begin
                  report_mismatch("beat mismatch", want, got);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int i;
      int p;
      asfd_pkg::cfg_type c;
      model_cfg.step_thr = asfd_pkg::RST_STEP_THR;
      model_cfg.step_min = asfd_pkg::RST_STEP_MIN;
      model_cfg.free_fall = asfd_pkg::RST_FREE_FALL;
      model_cfg.impact = asfd_pkg::RST_IMPACT;
      model_cfg.fall_win = asfd_pkg::RST_FALL_WIN;
      model_cfg.still_low = asfd_pkg::RST_STILL_LOW;
      model_cfg.still_high = asfd_pkg::RST_STILL_HIGH;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         push_sample(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, DIRECTED[i].t,
                     DIRECTED[i].known, DIRECTED[i].res);
      end
      wait_drained();

      for (p = 0; p < 6; p++) begin
         case (p)
            0: c = model_cfg;
            1: c = '0;
            2: c = '1;
            default: begin
               c.step_thr = 20'($urandom_range(30000, 200000));
               c.step_min = 16'($urandom_range(0, 600));
               c.free_fall = 20'($urandom_range(0, 60000));
               c.impact = 20'($urandom_range(200000, 786432));
               c.fall_win = 16'($urandom_range(0, 1000));
               c.still_low = 20'($urandom_range(0, 80000));
               c.still_high = 20'($urandom_range(60000, 200000));
            end
         endcase
         apply_config(c);
         sender_gaps = (p < 5) && ($urandom_range(0, 3) != 0);
         receiver_gaps = (p < 5) && ($urandom_range(0, 3) != 0);
         clock_ms = $urandom;
         send_random(100);
         wait_drained();
      end

      if (mismatch_count == 0 && expected_motion.size() == 0) begin
         $display("tb_accel_step_and_fall_detector passed");
      end else begin
         $display("tb_accel_step_and_fall_detector failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/asfd_pkg.sv
hdl/asfd_front.sv
hdl/asfd_queue.sv
hdl/asfd_back.sv
hdl/accel_step_and_fall_detector.sv
dv/tb_accel_step_and_fall_detector.sv
